### design/feistel_index_permuter_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the index permuter
// Shared macros for concurrent checks on the clock and reset of the block.
// ----------------------------------------------------------------------------
`ifndef FEISTEL_INDEX_PERMUTER_MACROS_SVH
`define FEISTEL_INDEX_PERMUTER_MACROS_SVH

// Same-cycle implication, switched off while reset is asserted.
`define FIP_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, live during reset as well.
`define FIP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

### design/fip_pkg.sv
// ----------------------------------------------------------------------------
// Index permuter package
// Field widths, opcodes, register indexes and the modular arithmetic helpers.
// ----------------------------------------------------------------------------
package fip_pkg;

    localparam int WORD_W         = 32;
    localparam int LEFT_W         = 10;
    localparam int SLOT_W         = 10;
    localparam int ROUND_W        = 3;
    localparam int INDEX_W        = 20;
    localparam int RB_CFG_W       = 4;
    localparam int MIN_RIGHT_BITS = 5;
    localparam int DIGIT_W        = 8;
    localparam int REDUCE_STAGES  = WORD_W / DIGIT_W;

    // Register indexes on the configuration port.
    localparam logic REG_RIGHT_BITS = 1'b0;
    localparam logic REG_LEFT_MOD   = 1'b1;

    typedef enum logic {
        OP_WRITE   = 1'b0,
        OP_PERMUTE = 1'b1
    } t_opcode;

    // Folds one digit of the table word into a running remainder.
    function automatic logic [LEFT_W-1:0] mod_digit(input logic [LEFT_W-1:0]  rem,
                                                    input logic [DIGIT_W-1:0] digit,
                                                    input logic [LEFT_W-1:0]  modulus);
        logic [LEFT_W:0] acc;
        acc = {1'b0, rem};
        for (int i = DIGIT_W - 1; i >= 0; i--) begin
            acc = {acc[LEFT_W-1:0], digit[i]};
            if (acc >= {1'b0, modulus}) begin
                acc = acc - {1'b0, modulus};
            end
        end
        return acc[LEFT_W-1:0];
    endfunction

    // Adds two residues and brings the sum back below the modulus.
    function automatic logic [LEFT_W-1:0] add_mod(input logic [LEFT_W-1:0] a,
                                                  input logic [LEFT_W-1:0] b,
                                                  input logic [LEFT_W-1:0] modulus);
        logic [LEFT_W:0] sum;
        sum = {1'b0, a} + {1'b0, b};
        if (sum >= {1'b0, modulus}) begin
            sum = sum - {1'b0, modulus};
        end
        return sum[LEFT_W-1:0];
    endfunction

endpackage

### design/fip_entry.sv
// ----------------------------------------------------------------------------
// Index permuter entry stage
// Splits the index into its halves and flags indexes outside the domain.
// ----------------------------------------------------------------------------
module fip_entry #(
    parameter int  MAX_RIGHT_BITS = 10,
    parameter type t_item         = logic
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  fip_pkg::t_opcode              i_op,
    input  logic [fip_pkg::ROUND_W-1:0]   i_round,
    input  logic [fip_pkg::SLOT_W-1:0]    i_slot,
    input  logic [fip_pkg::WORD_W-1:0]    i_word,
    input  logic [fip_pkg::INDEX_W-1:0]   i_index,
    input  logic [fip_pkg::RB_CFG_W-1:0]  i_right_bits,
    input  logic [fip_pkg::LEFT_W-1:0]    i_left_mod,
    output logic                          o_valid,
    output t_item                         o_item,
    input  logic                          i_ready
);
    import fip_pkg::*;

    localparam int RBW   = $clog2(MAX_RIGHT_BITS + 1);
    localparam int SZ_W  = LEFT_W + MAX_RIGHT_BITS;
    localparam int CMP_W = (SZ_W > INDEX_W) ? SZ_W : INDEX_W;

    logic                      r_valid;
    t_item                     r_item;
    t_item                     n_item;
    logic                      w_load;
    logic [RBW-1:0]            w_rb;
    logic [MAX_RIGHT_BITS-1:0] w_mask;
    logic [CMP_W-1:0]          w_size;

    // Effective width of the right half, held inside its legal range.
    always_comb begin
        if (i_right_bits < RB_CFG_W'(MIN_RIGHT_BITS)) begin
            w_rb = RBW'(MIN_RIGHT_BITS);
        end else if (int'(i_right_bits) > MAX_RIGHT_BITS) begin
            w_rb = RBW'(MAX_RIGHT_BITS);
        end else begin
            w_rb = RBW'(i_right_bits);
        end
    end

    assign w_mask = {MAX_RIGHT_BITS{1'b1}} >> (MAX_RIGHT_BITS - int'(w_rb));
    assign w_size = CMP_W'(i_left_mod) << w_rb;

    // Next word for the stage register.
    always_comb begin
        n_item       = r_item;
        n_item.op    = i_op;
        n_item.round = i_round;
        n_item.slot  = i_slot;
        n_item.word  = i_word;
        n_item.rb    = w_rb;
        n_item.oor   = (i_left_mod == '0) || (CMP_W'(i_index) >= w_size);
        n_item.left  = LEFT_W'(i_index >> w_rb);
        n_item.right = MAX_RIGHT_BITS'(i_index) & w_mask;
        n_item.rem   = '0;
    end

    assign w_load  = !r_valid || i_ready;
    assign o_ready = w_load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_load) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_item <= n_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

### design/fip_round.sv
// ----------------------------------------------------------------------------
// Index permuter round
// One Feistel round: its table memory, then either a modular add of the
// table word into the left half or an XOR of it into the right half.
// ----------------------------------------------------------------------------
module fip_round #(
    parameter int  MAX_RIGHT_BITS = 10,
    parameter int  ROUND_IDX      = 0,
    parameter type t_item         = logic
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  t_item                      i_item,
    input  logic [fip_pkg::LEFT_W-1:0] i_left_mod,
    output logic                       o_valid,
    output t_item                      o_item,
    input  logic                       i_ready
);
    import fip_pkg::*;

    localparam bit EVEN  = (ROUND_IDX % 2) == 0;
    localparam int NS    = EVEN ? REDUCE_STAGES + 2 : 2;
    localparam int DEPTH = 2 ** MAX_RIGHT_BITS;

    logic [WORD_W-1:0]         r_mem [DEPTH];
    logic [WORD_W-1:0]         r_rdata;
    logic                      r_valid [NS];
    t_item                     r_item [NS];
    t_item                     n_item [NS];
    t_item                     w_out [NS];
    logic                      w_load [NS];
    logic [MAX_RIGHT_BITS-1:0] w_addr;

    // Even rounds look up by the right half, odd rounds by the left half.
    assign w_addr = EVEN ? i_item.right : MAX_RIGHT_BITS'(i_item.left);

    // Table port: a load word writes as it passes, a query reads.
    always_ff @(posedge i_clk) begin
        if (w_load[0] && i_valid) begin
            if (i_item.op == OP_WRITE) begin
                if ((i_item.round == ROUND_W'(ROUND_IDX)) &&
                    ((i_item.slot >> MAX_RIGHT_BITS) == '0)) begin
                    r_mem[MAX_RIGHT_BITS'(i_item.slot)] <= i_item.word;
                end
            end else begin
                r_rdata <= r_mem[w_addr];
            end
        end
    end

    assign n_item[0] = i_item;

    // A query leaves the table stage carrying the word it read.
    always_comb begin
        w_out[0] = r_item[0];
        if (r_item[0].op == OP_PERMUTE) begin
            w_out[0].word = r_rdata;
        end
    end

    genvar k;
    generate
        for (k = 0; k < NS; k++) begin : g_stage
            if (k == NS - 1) begin : g_last
                assign w_load[k] = !r_valid[k] || i_ready;
            end else begin : g_mid
                assign w_load[k] = !r_valid[k] || w_load[k+1];
            end

            if (k > 0) begin : g_work
                assign w_out[k] = r_item[k];
                if (EVEN && (k <= REDUCE_STAGES)) begin : g_reduce
                    // One digit of the table word folded into the remainder.
                    always_comb begin
                        n_item[k]     = w_out[k-1];
                        n_item[k].rem = mod_digit(
                            (k == 1) ? '0 : w_out[k-1].rem,
                            w_out[k-1].word[WORD_W-1-DIGIT_W*(k-1) -: DIGIT_W],
                            i_left_mod);
                    end
                end else if (EVEN) begin : g_add
                    // Left half plus the reduced word, modulo left_mod.
                    always_comb begin
                        n_item[k]      = w_out[k-1];
                        n_item[k].left = add_mod(w_out[k-1].left, w_out[k-1].rem,
                                                 i_left_mod);
                    end
                end else begin : g_xor
                    // Right half XOR the word masked to the right width.
                    always_comb begin
                        n_item[k]       = w_out[k-1];
                        n_item[k].right = w_out[k-1].right ^
                            (w_out[k-1].word[MAX_RIGHT_BITS-1:0] &
                             ({MAX_RIGHT_BITS{1'b1}} >>
                              (MAX_RIGHT_BITS - int'(w_out[k-1].rb))));
                    end
                end
            end

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_valid[k] <= 1'b0;
                end else if (w_load[k]) begin
                    r_valid[k] <= (k == 0) ? i_valid : r_valid[(k == 0) ? 0 : k - 1];
                end
            end

            always_ff @(posedge i_clk) begin
                if (w_load[k]) begin
                    r_item[k] <= n_item[k];
                end
            end
        end
    endgenerate

    assign o_ready = w_load[0];
    assign o_valid = r_valid[NS-1];
    assign o_item  = w_out[NS-1];

endmodule

### design/fip_exit.sv
// ----------------------------------------------------------------------------
// Index permuter output stage
// Joins the halves into the result word and drops table loads.
// ----------------------------------------------------------------------------
module fip_exit #(
    parameter int  MAX_RIGHT_BITS = 10,
    parameter type t_item         = logic
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  t_item                       i_item,
    output logic                        o_valid,
    output logic [fip_pkg::INDEX_W-1:0] o_index,
    output logic                        o_oor,
    input  logic                        i_ready
);
    import fip_pkg::*;

    localparam int JW = LEFT_W + MAX_RIGHT_BITS;

    logic                r_valid;
    logic [INDEX_W-1:0]  r_index;
    logic                r_oor;
    logic                w_load;
    logic [JW-1:0]       w_joined;

    assign w_joined = (JW'(i_item.left) << i_item.rb) | JW'(i_item.right);
    assign w_load   = !r_valid || i_ready;
    assign o_ready  = w_load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_load) begin
            r_valid <= i_valid && (i_item.op == OP_PERMUTE);
        end
    end

    // Result register; an index outside the domain reads as zero.
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_oor   <= i_item.oor;
            r_index <= i_item.oor ? '0 : INDEX_W'(w_joined);
        end
    end

    assign o_valid = r_valid;
    assign o_index = r_index;
    assign o_oor   = r_oor;

endmodule

### design/feistel_index_permuter.sv
// ----------------------------------------------------------------------------
// Keyed index permuter
// Five-round mixed-radix Feistel bijection over [0, left_mod << right_bits),
// with per-round table memories loaded through the input stream.
// ----------------------------------------------------------------------------
//  channel | direction | fields
//  s_axis  | in        | tuser: opcode; tdata: table_round, table_slot,
//          |           |   table_word, element_index
//  m_axis  | out       | tuser: out_of_range; tdata: permuted_index
//  apb     | in        | right_bits at 0x0, left_mod at 0x4
//
// One word is taken every cycle unless a stall at the output holds the pipeline.
// Each even round passes through its table stage, the digit-serial reduction
// stages and the add stage in turn. Table loads travel down the pipeline and
// write each table as they pass, so queries see loads in stream order. Ready
// runs back combinationally: a stall at the output reaches the input in the same
// cycle only when every stage is full, and any empty stage absorbs it. Reset
// clears every valid bit, not the tables.
// ----------------------------------------------------------------------------
`include "feistel_index_permuter_macros.svh"

module feistel_index_permuter #(
    parameter int MAX_RIGHT_BITS = 10,
    parameter int ROUND_COUNT    = 5
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [71:0] s_axis_tdata,   // table_round, table_slot, table_word, element_index
    input  logic        s_axis_tuser,   // opcode
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // permuted_index
    output logic        m_axis_tuser,   // out_of_range
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import fip_pkg::*;

    localparam int RBW      = $clog2(MAX_RIGHT_BITS + 1);
    localparam int SLOT_LO  = ROUND_W;
    localparam int WORD_LO  = SLOT_LO + SLOT_W;
    localparam int INDEX_LO = WORD_LO + WORD_W;

    typedef struct packed {
        t_opcode                   op;
        logic [ROUND_W-1:0]        round;
        logic [SLOT_W-1:0]         slot;
        logic [WORD_W-1:0]         word;
        logic                      oor;
        logic [RBW-1:0]            rb;
        logic [LEFT_W-1:0]         left;
        logic [MAX_RIGHT_BITS-1:0] right;
        logic [LEFT_W-1:0]         rem;
    } t_item;

    logic [RB_CFG_W-1:0] r_right_bits;
    logic [LEFT_W-1:0]   r_left_mod;
    logic                w_valid [ROUND_COUNT+1];
    logic                w_ready [ROUND_COUNT+1];
    t_item               w_item [ROUND_COUNT+1];
    logic [INDEX_W-1:0]  w_index;

    // Configuration registers, written on the access cycle.
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_right_bits <= RB_CFG_W'(10);
            r_left_mod   <= LEFT_W'(1023);
        end else if (psel && penable && pwrite && pready) begin
            unique case (paddr[2])
                REG_RIGHT_BITS: r_right_bits <= pwdata[RB_CFG_W-1:0];
                REG_LEFT_MOD:   r_left_mod   <= pwdata[LEFT_W-1:0];
                default:        ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_RIGHT_BITS: prdata = 32'(r_right_bits);
            REG_LEFT_MOD:   prdata = 32'(r_left_mod);
            default:        prdata = '0;
        endcase
    end

    // Entry stage.
    fip_entry #(
        .MAX_RIGHT_BITS (MAX_RIGHT_BITS),
        .t_item         (t_item)
    ) u_entry (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (s_axis_tvalid),
        .o_ready      (s_axis_tready),
        .i_op         (t_opcode'(s_axis_tuser)),
        .i_round      (s_axis_tdata[SLOT_LO-1:0]),
        .i_slot       (s_axis_tdata[WORD_LO-1:SLOT_LO]),
        .i_word       (s_axis_tdata[INDEX_LO-1:WORD_LO]),
        .i_index      (s_axis_tdata[INDEX_LO+INDEX_W-1:INDEX_LO]),
        .i_right_bits (r_right_bits),
        .i_left_mod   (r_left_mod),
        .o_valid      (w_valid[0]),
        .o_item       (w_item[0]),
        .i_ready      (w_ready[0])
    );

    // Rounds in sequence.
    genvar r;
    generate
        for (r = 0; r < ROUND_COUNT; r++) begin : g_round
            fip_round #(
                .MAX_RIGHT_BITS (MAX_RIGHT_BITS),
                .ROUND_IDX      (r),
                .t_item         (t_item)
            ) u_round (
                .i_clk      (i_clk),
                .i_rst_n    (i_rst_n),
                .i_valid    (w_valid[r]),
                .o_ready    (w_ready[r]),
                .i_item     (w_item[r]),
                .i_left_mod (r_left_mod),
                .o_valid    (w_valid[r+1]),
                .o_item     (w_item[r+1]),
                .i_ready    (w_ready[r+1])
            );
        end
    endgenerate

    // Result register.
    fip_exit #(
        .MAX_RIGHT_BITS (MAX_RIGHT_BITS),
        .t_item         (t_item)
    ) u_exit (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_valid[ROUND_COUNT]),
        .o_ready (w_ready[ROUND_COUNT]),
        .i_item  (w_item[ROUND_COUNT]),
        .o_valid (m_axis_tvalid),
        .o_index (w_index),
        .o_oor   (m_axis_tuser),
        .i_ready (m_axis_tready)
    );

    assign m_axis_tdata = 24'(w_index);

    // Checks.
    `FIP_ASSERT_IMPL(a_oor_zero, m_axis_tvalid && m_axis_tuser, w_index == '0,
                     "out-of-range result carries a non-zero index")
    `FIP_ASSERT_NEXT(a_rst_clear, !i_rst_n, !m_axis_tvalid && !w_valid[0],
                     "valid still set after reset")

endmodule
